// ===== hw/rtl/aob_pkg.sv =====
package aob_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int AW_W       = 5;
   localparam int ALPHA_W    = 16;
   localparam int NORM_W     = 17;
   localparam int FRAC_W     = 16;

   localparam logic [NORM_W-1:0] NORM_ONE = 17'h10000;
   localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

   localparam logic [CSR_IDX_W-1:0] CSR_FG_AW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_AW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_AW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_PM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_PM   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_PM  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR   = 3'd6;

   function automatic logic [ALPHA_W-1:0] code_max(input logic [AW_W-1:0] w);
      logic [AW_W-1:0] we;
      we = (w == 5'd0) ? 5'd1 : ((w > 5'd16) ? 5'd16 : w);
      return ALPHA_W'((17'd1 << we) - 17'd1);
   endfunction

endpackage

// ===== hw/rtl/aob_div.sv =====
module aob_div #(
   parameter int XW = 32,
   parameter int QW = 17,
   parameter int MW = 16,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          src_valid,
   input  logic [XW-1:0] src_x,
   input  logic [MW-1:0] src_m,
   input  logic [TW-1:0] src_tag,
   output logic          res_valid,
   output logic [QW-1:0] res_q,
   output logic          res_ovf,
   output logic [TW-1:0] res_tag
);

   localparam int HW = XW - QW;
   localparam int EW = (HW > MW) ? HW : MW;

   logic [EW-1:0] hi_in;
   logic [EW-1:0] m_in;
   logic          ovf_in;

   logic          vld_ff [QW+1];
   logic [MW-1:0] rem_ff [QW+1];
   logic [QW-1:0] acc_ff [QW+1];
   logic [MW-1:0] m_ff   [QW+1];
   logic [TW-1:0] tag_ff [QW+1];
   logic          ovf_ff [QW+1];

   always_comb begin
      hi_in  = EW'(src_x >> QW);
      m_in   = EW'(src_m);
      ovf_in = (hi_in >= m_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= MW'(src_x >> QW);
      acc_ff[0] <= src_x[QW-1:0];
      m_ff[0]   <= src_m;
      tag_ff[0] <= src_tag;
      ovf_ff[0] <= ovf_in;
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [MW:0] trial_in;
      logic [MW:0] diff_in;
      logic        take_in;

      always_comb begin
         trial_in = {rem_ff[k], acc_ff[k][QW-1]};
         diff_in  = trial_in - {1'b0, m_ff[k]};
         take_in  = (trial_in >= {1'b0, m_ff[k]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= take_in ? diff_in[MW-1:0] : trial_in[MW-1:0];
         acc_ff[k+1] <= {acc_ff[k][QW-2:0], take_in};
         m_ff[k+1]   <= m_ff[k];
         tag_ff[k+1] <= tag_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   assign res_valid = vld_ff[QW];
   assign res_q     = acc_ff[QW];
   assign res_ovf   = ovf_ff[QW];
   assign res_tag   = tag_ff[QW];

endmodule

// ===== hw/rtl/alpha_over_blend_top.sv =====
// Alpha "over" compositing, one pixel per item.
// Input: pulse start with the foreground and background pixel on req_*; the
// item is taken at that edge. busy is always low, so an item may be started
// in every cycle.
// Output: rsp_valid is high for exactly one cycle with the blended pixel on
// rsp_*; results leave in the order items entered. The receiver cannot stall.
// Throughput: one item per cycle. The latency is set by three chained
// restoring dividers, one quotient bit per stage: alpha normalization,
// output alpha renormalization and the per-channel colour divide
// (COLOR_WIDTH + 16 quotient bits).
// Configuration: csr_write_en with csr_index and csr_data writes one register;
// write only while no item is in flight.
// Reset: synchronous; clears the registers to their defaults and drops all
// items in flight.
module alpha_over_blend_top #(
   parameter int COLOR_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [15:0]                   req_fg_red,
   input  logic [15:0]                   req_fg_green,
   input  logic [15:0]                   req_fg_blue,
   input  logic [15:0]                   req_fg_alpha,
   input  logic [15:0]                   req_bg_red,
   input  logic [15:0]                   req_bg_green,
   input  logic [15:0]                   req_bg_blue,
   input  logic [15:0]                   req_bg_alpha,
   input  logic                          csr_write_en,
   input  logic [aob_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aob_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                          rsp_valid,
   output logic [15:0]                   rsp_out_red,
   output logic [15:0]                   rsp_out_green,
   output logic [15:0]                   rsp_out_blue,
   output logic [15:0]                   rsp_out_alpha
);

   import aob_pkg::*;

   localparam int CW  = COLOR_WIDTH;
   localparam int PW  = CW + 1;
   localparam int MPW = CW + NORM_W;
   localparam int QCW = CW + FRAC_W;
   localparam int XCW = PW + FRAC_W;
   localparam int FPW = QCW + NORM_W;
   localparam int ATW = 3 * CW;
   localparam int BTW = NORM_W + 3 * PW + ALPHA_W;
   localparam int C0W = PW + 1 + NORM_W + ALPHA_W;
   localparam logic [CW-1:0] CMAX = {CW{1'b1}};

   // configuration
   logic [AW_W-1:0]   fg_aw_ff, bg_aw_ff, out_aw_ff;
   logic              fg_pm_ff, bg_pm_ff, out_pm_ff;
   logic [FRAC_W-1:0] floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_aw_ff  <= 5'd8;
         bg_aw_ff  <= 5'd8;
         out_aw_ff <= 5'd8;
         fg_pm_ff  <= 1'b0;
         bg_pm_ff  <= 1'b0;
         out_pm_ff <= 1'b0;
         floor_ff  <= 16'd1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FG_AW:  fg_aw_ff  <= csr_data[AW_W-1:0];
            CSR_BG_AW:  bg_aw_ff  <= csr_data[AW_W-1:0];
            CSR_OUT_AW: out_aw_ff <= csr_data[AW_W-1:0];
            CSR_FG_PM:  fg_pm_ff  <= csr_data[0];
            CSR_BG_PM:  bg_pm_ff  <= csr_data[0];
            CSR_OUT_PM: out_pm_ff <= csr_data[0];
            CSR_FLOOR:  floor_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   logic [ALPHA_W-1:0] fg_max, bg_max, out_max;
   logic               straight;

   always_comb begin
      fg_max   = code_max(fg_aw_ff);
      bg_max   = code_max(bg_aw_ff);
      out_max  = code_max(out_aw_ff);
      straight = !fg_pm_ff && !bg_pm_ff;
   end

   assign busy = 1'b0;

   // entry: saturate alpha codes, build normalization dividends
   logic [ALPHA_W-1:0] fa_code_in, ba_code_in;
   logic [2*ALPHA_W-1:0] fa_x_in, ba_x_in;
   logic [ATW-1:0] ftag_in, btag_in;
   logic [CW-1:0] fc_in [3];
   logic [CW-1:0] bc_in [3];

   always_comb begin
      fc_in[0] = CW'(req_fg_red);
      fc_in[1] = CW'(req_fg_green);
      fc_in[2] = CW'(req_fg_blue);
      bc_in[0] = CW'(req_bg_red);
      bc_in[1] = CW'(req_bg_green);
      bc_in[2] = CW'(req_bg_blue);
      for (int ch = 0; ch < 3; ch++) begin
         ftag_in[ch*CW +: CW] = fc_in[ch];
         btag_in[ch*CW +: CW] = bc_in[ch];
      end
      fa_code_in = (req_fg_alpha > fg_max) ? fg_max : req_fg_alpha;
      ba_code_in = (req_bg_alpha > bg_max) ? bg_max : req_bg_alpha;
      fa_x_in    = {fa_code_in, ALPHA_W'(fg_max >> 1)};
      ba_x_in    = {ba_code_in, ALPHA_W'(bg_max >> 1)};
   end

   logic              a_fvalid, a_bvalid, a_fovf, a_bovf;
   logic [NORM_W-1:0] a_fa, a_ba;
   logic [ATW-1:0]    a_ftag, a_btag;

   aob_div #(.XW(2*ALPHA_W), .QW(NORM_W), .MW(ALPHA_W), .TW(ATW)) u_div_fa (
      .clock(clock), .reset(reset),
      .src_valid(start), .src_x(fa_x_in), .src_m(fg_max), .src_tag(ftag_in),
      .res_valid(a_fvalid), .res_q(a_fa), .res_ovf(a_fovf), .res_tag(a_ftag)
   );

   aob_div #(.XW(2*ALPHA_W), .QW(NORM_W), .MW(ALPHA_W), .TW(ATW)) u_div_ba (
      .clock(clock), .reset(reset),
      .src_valid(start), .src_x(ba_x_in), .src_m(bg_max), .src_tag(btag_in),
      .res_valid(a_bvalid), .res_q(a_ba), .res_ovf(a_bovf), .res_tag(a_btag)
   );

   // stage 1: alpha and colour products
   logic              v1_ff;
   logic [2*NORM_W-1:0] s1_ab_ff;
   logic [NORM_W-1:0] s1_invf_ff;
   logic [CW-1:0]     s1_fc_ff [3];
   logic [CW-1:0]     s1_bc_ff [3];
   logic [MPW-1:0]    s1_fp_ff [3];
   logic [MPW-1:0]    s1_bp_ff [3];
   logic [NORM_W-1:0] invf_in, invb_in;

   always_comb begin
      invf_in = NORM_ONE - a_fa;
      invb_in = NORM_ONE - a_ba;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= a_fvalid;
      end
   end

   always_ff @(posedge clock) begin
      s1_ab_ff   <= invf_in * invb_in;
      s1_invf_ff <= invf_in;
      for (int ch = 0; ch < 3; ch++) begin
         s1_fc_ff[ch] <= a_ftag[ch*CW +: CW];
         s1_bc_ff[ch] <= a_btag[ch*CW +: CW];
         s1_fp_ff[ch] <= MPW'(a_ftag[ch*CW +: CW]) * MPW'(a_fa);
         s1_bp_ff[ch] <= MPW'(a_btag[ch*CW +: CW]) * MPW'(a_ba);
      end
   end

   // stage 2: round products, combined alpha
   logic              v2_ff;
   logic [NORM_W-1:0] s2_na_ff, s2_invf_ff;
   logic [CW-1:0]     s2_ft_ff [3];
   logic [CW-1:0]     s2_bt_ff [3];
   logic [NORM_W-1:0] na_in;
   logic [2*NORM_W-1:0] ab_rnd_in;
   logic [MPW-1:0]    fp_rnd_in [3];
   logic [MPW-1:0]    bp_rnd_in [3];

   always_comb begin
      ab_rnd_in = s1_ab_ff + (2*NORM_W)'(ROUND_HALF);
      na_in     = NORM_ONE - NORM_W'(ab_rnd_in >> FRAC_W);
      for (int ch = 0; ch < 3; ch++) begin
         fp_rnd_in[ch] = s1_fp_ff[ch] + MPW'(ROUND_HALF);
         bp_rnd_in[ch] = s1_bp_ff[ch] + MPW'(ROUND_HALF);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_na_ff   <= na_in;
      s2_invf_ff <= s1_invf_ff;
      for (int ch = 0; ch < 3; ch++) begin
         s2_ft_ff[ch] <= fg_pm_ff ? s1_fc_ff[ch] : CW'(fp_rnd_in[ch] >> FRAC_W);
         s2_bt_ff[ch] <= bg_pm_ff ? s1_bc_ff[ch] : CW'(bp_rnd_in[ch] >> FRAC_W);
      end
   end

   // stage 3: output alpha product, background weight
   logic                       v3_ff;
   logic [NORM_W+ALPHA_W-1:0]  s3_op_ff;
   logic [NORM_W-1:0]          s3_na_ff;
   logic [CW-1:0]              s3_ft_ff [3];
   logic [MPW-1:0]             s3_bw_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_op_ff <= (NORM_W+ALPHA_W)'(s2_na_ff) * (NORM_W+ALPHA_W)'(out_max);
      s3_na_ff <= s2_na_ff;
      for (int ch = 0; ch < 3; ch++) begin
         s3_ft_ff[ch] <= s2_ft_ff[ch];
         s3_bw_ff[ch] <= MPW'(s2_bt_ff[ch]) * MPW'(s2_invf_ff);
      end
   end

   // stage 4: output alpha code, blended sums
   logic                      v4_ff;
   logic [ALPHA_W-1:0]        s4_oa_ff;
   logic [NORM_W-1:0]         s4_na_ff;
   logic [PW-1:0]             s4_p_ff [3];
   logic [NORM_W+ALPHA_W-1:0] op_rnd_in;
   logic [MPW-1:0]            bw_rnd_in [3];

   always_comb begin
      op_rnd_in = s3_op_ff + (NORM_W+ALPHA_W)'(ROUND_HALF);
      for (int ch = 0; ch < 3; ch++) begin
         bw_rnd_in[ch] = s3_bw_ff[ch] + MPW'(ROUND_HALF);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_oa_ff <= ALPHA_W'(op_rnd_in >> FRAC_W);
      s4_na_ff <= s3_na_ff;
      for (int ch = 0; ch < 3; ch++) begin
         s4_p_ff[ch] <= PW'(s3_ft_ff[ch]) + PW'(bw_rnd_in[ch] >> FRAC_W);
      end
   end

   // renormalize output alpha
   logic [2*ALPHA_W-1:0] oa_x_in;
   logic [BTW-1:0]       btag_b_in, b_tag;
   logic                 b_valid, b_ovf;
   logic [NORM_W-1:0]    b_oan;

   always_comb begin
      oa_x_in = {s4_oa_ff, ALPHA_W'(out_max >> 1)};
      btag_b_in = {s4_na_ff, s4_p_ff[0], s4_p_ff[1], s4_p_ff[2], s4_oa_ff};
   end

   aob_div #(.XW(2*ALPHA_W), .QW(NORM_W), .MW(ALPHA_W), .TW(BTW)) u_div_oa (
      .clock(clock), .reset(reset),
      .src_valid(v4_ff), .src_x(oa_x_in), .src_m(out_max), .src_tag(btag_b_in),
      .res_valid(b_valid), .res_q(b_oan), .res_ovf(b_ovf), .res_tag(b_tag)
   );

   // stage 5: floor alpha, pick divisor
   logic              v5_ff;
   logic [NORM_W-1:0] s5_d_ff, s5_mult_ff;
   logic              s5_dz_ff;
   logic [ALPHA_W-1:0] s5_oa_ff;
   logic [PW-1:0]     s5_p_ff [3];
   logic [NORM_W-1:0] mult_in, d_in, b_na;

   always_comb begin
      b_na    = b_tag[BTW-1 -: NORM_W];
      mult_in = (b_oan > NORM_W'(floor_ff)) ? b_oan : NORM_W'(floor_ff);
      d_in    = straight ? b_na : mult_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      s5_d_ff    <= d_in;
      s5_dz_ff   <= (d_in == '0);
      s5_mult_ff <= mult_in;
      s5_oa_ff   <= b_tag[ALPHA_W-1:0];
      s5_p_ff[0] <= b_tag[ALPHA_W+2*PW +: PW];
      s5_p_ff[1] <= b_tag[ALPHA_W+PW +: PW];
      s5_p_ff[2] <= b_tag[ALPHA_W +: PW];
   end

   // per-channel colour divide
   logic [XCW-1:0] cx_in [3];
   logic [C0W-1:0] c0_tag_in, c0_tag;
   logic [PW-1:0]  c1_tag, c2_tag;
   logic           c_valid [3];
   logic           c_ovf [3];
   logic [QCW-1:0] c_q [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         cx_in[ch] = {s5_p_ff[ch], FRAC_W'(s5_d_ff >> 1)};
      end
      c0_tag_in = {s5_dz_ff, s5_mult_ff, s5_oa_ff, s5_p_ff[0]};
   end

   aob_div #(.XW(XCW), .QW(QCW), .MW(NORM_W), .TW(C0W)) u_div_c0 (
      .clock(clock), .reset(reset),
      .src_valid(v5_ff), .src_x(cx_in[0]), .src_m(s5_d_ff), .src_tag(c0_tag_in),
      .res_valid(c_valid[0]), .res_q(c_q[0]), .res_ovf(c_ovf[0]), .res_tag(c0_tag)
   );

   aob_div #(.XW(XCW), .QW(QCW), .MW(NORM_W), .TW(PW)) u_div_c1 (
      .clock(clock), .reset(reset),
      .src_valid(v5_ff), .src_x(cx_in[1]), .src_m(s5_d_ff), .src_tag(s5_p_ff[1]),
      .res_valid(c_valid[1]), .res_q(c_q[1]), .res_ovf(c_ovf[1]), .res_tag(c1_tag)
   );

   aob_div #(.XW(XCW), .QW(QCW), .MW(NORM_W), .TW(PW)) u_div_c2 (
      .clock(clock), .reset(reset),
      .src_valid(v5_ff), .src_x(cx_in[2]), .src_m(s5_d_ff), .src_tag(s5_p_ff[2]),
      .res_valid(c_valid[2]), .res_q(c_q[2]), .res_ovf(c_ovf[2]), .res_tag(c2_tag)
   );

   // stage 6: premultiply product
   logic               v6_ff, s6_dz_ff;
   logic [NORM_W-1:0]  s6_mult_ff;
   logic [ALPHA_W-1:0] s6_oa_ff;
   logic [QCW-1:0]     s6_q_ff [3];
   logic               s6_ovf_ff [3];
   logic [PW-1:0]      s6_p_ff [3];
   logic [FPW-1:0]     s6_prod_ff [3];
   logic [NORM_W-1:0]  c_mult;

   assign c_mult = c0_tag[PW+ALPHA_W +: NORM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= c_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      s6_dz_ff   <= c0_tag[C0W-1];
      s6_mult_ff <= c_mult;
      s6_oa_ff   <= c0_tag[PW +: ALPHA_W];
      s6_p_ff[0] <= c0_tag[PW-1:0];
      s6_p_ff[1] <= c1_tag;
      s6_p_ff[2] <= c2_tag;
      for (int ch = 0; ch < 3; ch++) begin
         s6_q_ff[ch]    <= c_q[ch];
         s6_ovf_ff[ch]  <= c_ovf[ch];
         s6_prod_ff[ch] <= FPW'(c_q[ch]) * FPW'(c_mult);
      end
   end

   // stage 7: select, saturate, drive result
   logic               rsp_valid_ff;
   logic [15:0]        rsp_col_ff [3];
   logic [ALPHA_W-1:0] rsp_alpha_ff;
   logic [FPW-1:0]     prod_rnd_in [3];
   logic [FPW-FRAC_W-1:0] pm_in [3];
   logic [CW-1:0]      col_in [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod_rnd_in[ch] = s6_prod_ff[ch] + FPW'(ROUND_HALF);
         pm_in[ch]       = (FPW-FRAC_W)'(prod_rnd_in[ch] >> FRAC_W);
         if (!straight && out_pm_ff) begin
            col_in[ch] = (s6_p_ff[ch] > PW'(CMAX)) ? CMAX : CW'(s6_p_ff[ch]);
         end else if (s6_dz_ff) begin
            col_in[ch] = '0;
         end else if (straight && out_pm_ff) begin
            if (s6_ovf_ff[ch]) begin
               col_in[ch] = (s6_mult_ff == '0) ? '0 : CMAX;
            end else begin
               col_in[ch] = (pm_in[ch] > (FPW-FRAC_W)'(CMAX)) ? CMAX : CW'(pm_in[ch]);
            end
         end else if (s6_ovf_ff[ch]) begin
            col_in[ch] = CMAX;
         end else begin
            col_in[ch] = (s6_q_ff[ch] > QCW'(CMAX)) ? CMAX : CW'(s6_q_ff[ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_alpha_ff <= s6_oa_ff;
      for (int ch = 0; ch < 3; ch++) begin
         rsp_col_ff[ch] <= 16'(col_in[ch]);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_col_ff[0];
   assign rsp_out_green = rsp_col_ff[1];
   assign rsp_out_blue  = rsp_col_ff[2];
   assign rsp_out_alpha = rsp_alpha_ff;

   a_alpha_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      a_fvalid == a_bvalid)
      else $error("alpha divider lanes out of step");

   a_alpha_no_ovf: assert property (@(posedge clock) disable iff (reset)
      a_fvalid |-> (!a_fovf && !a_bovf))
      else $error("alpha normalization overflowed");

   a_oa_no_ovf: assert property (@(posedge clock) disable iff (reset)
      b_valid |-> !b_ovf)
      else $error("output alpha renormalization overflowed");

   a_color_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (c_valid[0] == c_valid[1]) && (c_valid[0] == c_valid[2]))
      else $error("colour divider lanes out of step");

   a_rsp_follows_stage: assert property (@(posedge clock) disable iff (reset)
      v6_ff |=> rsp_valid)
      else $error("result strobe lost");

endmodule

// ===== dv/alpha_over_blend_top_tb.sv =====
module alpha_over_blend_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aob_pkg::*;

   localparam int CW = 16;
   localparam int LATENCY = CW + 60;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
   } pixel_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [15:0] req_fg_red, req_fg_green, req_fg_blue, req_fg_alpha;
   logic [15:0] req_bg_red, req_bg_green, req_bg_blue, req_bg_alpha;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic rsp_valid;
   logic [15:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;

   logic [4:0] fg_aw, bg_aw, out_aw;
   logic fg_pm, bg_pm, out_pm;
   logic [15:0] floor_q;

   pixel_type blended_q[$];
   int errors;
   int gap_pct;

   alpha_over_blend_top #(.COLOR_WIDTH(CW)) u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [63:0] alpha_max(input logic [4:0] w);
      int we;
      we = (w == 0) ? 1 : ((w > 16) ? 16 : int'(w));
      return (64'd1 << we) - 64'd1;
   endfunction

   function automatic logic [63:0] to_norm(input logic [63:0] a, input logic [4:0] w);
      logic [63:0] m;
      m = alpha_max(w);
      if (a > m) a = m;
      return (a * 64'd65536 + m / 64'd2) / m;
   endfunction

   function automatic logic [63:0] scale(input logic [63:0] c, input logic [63:0] f);
      return (c * f + 64'd32768) >> 16;
   endfunction

   function automatic logic [63:0] unscale(input logic [63:0] c, input logic [63:0] m);
      if (m == 0) return 64'd0;
      return (c * 64'd65536 + m / 64'd2) / m;
   endfunction

   function automatic pixel_type blend_over(input pixel_type fg, input pixel_type bg);
      logic [63:0] cmax, fa, ba, inv_f, na, oa, mult, fc, bc, ft, bt, p, c;
      logic [15:0] fgc[3], bgc[3];
      pixel_type r;
      cmax = (64'd1 << CW) - 64'd1;
      fa = to_norm(64'(fg.alpha), fg_aw);
      ba = to_norm(64'(bg.alpha), bg_aw);
      inv_f = 64'd65536 - fa;
      na = 64'd65536 - scale(inv_f, 64'd65536 - ba);
      oa = (na * alpha_max(out_aw) + 64'd32768) >> 16;
      mult = to_norm(oa, out_aw);
      if (mult < 64'(floor_q)) mult = 64'(floor_q);
      fgc = '{fg.red, fg.green, fg.blue};
      bgc = '{bg.red, bg.green, bg.blue};
      for (int ch = 0; ch < 3; ch++) begin
         fc = 64'(fgc[ch]) & cmax;
         bc = 64'(bgc[ch]) & cmax;
         ft = fg_pm ? fc : scale(fc, fa);
         bt = bg_pm ? bc : scale(bc, ba);
         p = ft + scale(bt, inv_f);
         if (!fg_pm && !bg_pm) begin
            c = (na == 0) ? 64'd0 : unscale(p, na);
            if (out_pm) c = scale(c, mult);
         end else begin
            c = out_pm ? p : unscale(p, mult);
         end
         if (c > cmax) c = cmax;
         fgc[ch] = c[15:0];
      end
      r.red = fgc[0];
      r.green = fgc[1];
      r.blue = fgc[2];
      r.alpha = oa[15:0];
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid) begin
         if (blended_q.size() == 0) begin
            $error("unexpected result");
            errors++;
         end else begin
            want = blended_q.pop_front();
            if (rsp_out_red !== want.red) begin
               $error("out_red exp %h got %h", want.red, rsp_out_red); errors++;
            end
            if (rsp_out_green !== want.green) begin
               $error("out_green exp %h got %h", want.green, rsp_out_green); errors++;
            end
            if (rsp_out_blue !== want.blue) begin
               $error("out_blue exp %h got %h", want.blue, rsp_out_blue); errors++;
            end
            if (rsp_out_alpha !== want.alpha) begin
               $error("out_alpha exp %h got %h", want.alpha, rsp_out_alpha); errors++;
            end
         end
      end
   end

   task automatic send_item(input pixel_type fg, input pixel_type bg);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      {req_fg_red, req_fg_green, req_fg_blue, req_fg_alpha} <= fg;
      {req_bg_red, req_bg_green, req_bg_blue, req_bg_alpha} <= bg;
      @(posedge clock);
      while (busy) @(posedge clock);
      blended_q.push_back(blend_over(fg, bg));
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (blended_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FG_AW: fg_aw = val[4:0];
         CSR_BG_AW: bg_aw = val[4:0];
         CSR_OUT_AW: out_aw = val[4:0];
         CSR_FG_PM: fg_pm = val[0];
         CSR_BG_PM: bg_pm = val[0];
         CSR_OUT_PM: out_pm = val[0];
         CSR_FLOOR: floor_q = val;
         default: ;
      endcase
   endtask

   task automatic set_mode(input logic [4:0] fw, input logic [4:0] bw, input logic [4:0] ow,
                           input logic [2:0] pm, input logic [15:0] fl);
      write_reg(CSR_FG_AW, 16'(fw));
      write_reg(CSR_BG_AW, 16'(bw));
      write_reg(CSR_OUT_AW, 16'(ow));
      write_reg(CSR_FG_PM, 16'(pm[2]));
      write_reg(CSR_BG_PM, 16'(pm[1]));
      write_reg(CSR_OUT_PM, 16'(pm[0]));
      write_reg(CSR_FLOOR, fl);
   endtask

   function automatic pixel_type rand_pixel(input logic [4:0] w);
      pixel_type p;
      p = {$urandom, $urandom};
      case ($urandom_range(5))
         0: p.alpha = '0;
         1: p.alpha = 16'(alpha_max(w));
         2: p.alpha = 16'($urandom_range(65535));
         default: p.alpha = 16'(64'($urandom) & alpha_max(w));
      endcase
      return p;
   endfunction

   task automatic test_directed();
      pixel_type lo, hi;
      lo = '0;
      hi = '1;
      gap_pct = 0;
      send_item(lo, lo);
      send_item(hi, hi);
      send_item(hi, lo);
      send_item(lo, hi);
      send_item('{16'h8000, 16'h7fff, 16'h0001, 16'h0080},
                '{16'hffff, 16'h0, 16'h4000, 16'h00ff});
      send_item('{16'h1234, 16'hfedc, 16'h8000, 16'h00ff}, '{16'h1, 16'h2, 16'h3, 16'h0});
      drain();
      for (int pm = 0; pm < 8; pm++) begin
         set_mode(5'd8, 5'd8, 5'd8, pm[2:0], 16'd0);
         send_item(lo, lo);
         send_item(hi, lo);
         send_item('{16'hffff, 16'hffff, 16'hffff, 16'h0001}, '{16'h0, 16'h0, 16'h0, 16'h0});
         drain();
      end
      set_mode(5'd0, 5'd31, 5'd17, 3'b111, 16'hffff);
      send_item(hi, hi);
      send_item('{16'h7fff, 16'h0, 16'hffff, 16'h1}, lo);
      drain();
      set_mode(5'd16, 5'd1, 5'd0, 3'b001, 16'd1);
      send_item(hi, '{16'hffff, 16'h1, 16'h8000, 16'h1});
      drain();
   endtask

   task automatic test_random(input int n, input int pct);
      gap_pct = pct;
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) begin
            drain();
            set_mode(5'($urandom_range(31)), 5'($urandom_range(31)),
                     5'($urandom_range(31)), 3'($urandom_range(7)),
                     ($urandom_range(3) == 0) ? 16'($urandom) :
                     16'($urandom_range(1)));
         end
         send_item(rand_pixel(fg_aw), rand_pixel(bg_aw));
      end
      drain();
   endtask

   initial begin
      errors = 0;
      gap_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      {req_fg_red, req_fg_green, req_fg_blue, req_fg_alpha} = '0;
      {req_bg_red, req_bg_green, req_bg_blue, req_bg_alpha} = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      fg_aw = 5'd8; bg_aw = 5'd8; out_aw = 5'd8;
      fg_pm = 1'b0; bg_pm = 1'b0; out_pm = 1'b0;
      floor_q = 16'd1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(350, 11);
      test_random(350, 79);
      test_random(350, 0);
      if (errors == 0 && blended_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/aob_pkg.sv
hw/rtl/aob_div.sv
hw/rtl/alpha_over_blend_top.sv
dv/alpha_over_blend_top_tb.sv
